/* rtl/core/scope_frame_parser_defines.svh */
// Assertion macros shared by the scope frame parser checkers.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SCOPE_FRAME_PARSER_DEFINES_SVH
`define SCOPE_FRAME_PARSER_DEFINES_SVH

// Concurrent assertion, clocked on clk, off during reset.
`define SFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication form: when cond holds, check holds in the same cycle.
`define SFP_ASSERT_IMPL(label, cond, check, msg) \
	`SFP_ASSERT(label, (cond) |-> (check), msg)

`endif

/* rtl/core/sfp_pkg.sv */
// Shared types and constants of the scope frame parser.
// No dependencies; every module file imports this package.
package sfp_pkg;

	localparam int unsigned FRAME_NUMBER_BYTES = 1;
	localparam int unsigned TIME_BYTES         = 4;
	localparam int unsigned HEADER_WORD_BYTES  = 4;
	localparam int unsigned SKIP_BYTES         = 6;
	localparam logic [7:0]  TYPE_ACCEPTED      = 8'd1;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_SKIP,
		PH_FNUM,
		PH_TYPE,
		PH_SLEN0,
		PH_SSKIP0,
		PH_SLEN1,
		PH_SSKIP1,
		PH_SLEN2,
		PH_SSKIP2,
		PH_XDIV,
		PH_YDIV,
		PH_COUNT,
		PH_XOFF,
		PH_TIME,
		PH_FEND,
		PH_FCPX,
		PH_FFLT,
		PH_FSIZE,
		PH_REAL,
		PH_IMAG
	} phase_t;

	typedef enum logic [3:0] {
		KIND_FNUM   = 4'd0,
		KIND_XDIV   = 4'd1,
		KIND_YDIV   = 4'd2,
		KIND_COUNT  = 4'd3,
		KIND_XOFF   = 4'd4,
		KIND_TIME   = 4'd5,
		KIND_FORMAT = 4'd6,
		KIND_SAMPLE = 4'd7,
		KIND_REJECT = 4'd8
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [63:0] imag_value;
		logic [31:0] sample_index;
		logic        is_complex;
		logic        is_float;
		logic [7:0]  point_size;
		logic        last;
	} res_word_t;

	// One registered input byte on its way into the parser.
	typedef struct packed {
		logic     valid;
		in_word_t word;
	} step_t;

	// One parser result on its way into the result register.
	typedef struct packed {
		logic      valid;
		res_word_t word;
	} result_t;

endpackage

/* rtl/core/sfp_in_stage.sv */
// Input register of the scope frame parser.
// Depends on sfp_pkg for the word and step types.
module sfp_in_stage
	import sfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     frame_valid,
	output logic     frame_stall,
	input  in_word_t frame_word,
	input  logic     advance,
	output step_t    step
);

	logic     valid_s1;
	in_word_t word_s1;
	logic     load;

	// Load when the register is empty or its byte moves on this cycle.
	assign load = advance || !valid_s1;

	// Hold the byte while the result side cannot take the next result.
	assign frame_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && frame_valid) begin
			word_s1 <= frame_word;
		end
	end

	assign step.valid = valid_s1;
	assign step.word  = word_s1;

endmodule

/* rtl/core/sfp_parser.sv */
// Frame parsing state and the per-byte next-state and result logic.
// Depends on sfp_pkg for phases, kinds and word types.
module sfp_parser
	import sfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  step_t   step,
	input  logic    advance,
	output result_t result
);

	phase_t      phase_q;
	logic [7:0]  bc_q;
	logic [7:0]  slen_q;
	logic [63:0] asm_q;
	logic [63:0] held_q;
	logic [31:0] total_q;
	logic [31:0] done_q;
	logic        big_q;
	logic        cpx_q;
	logic        flt_q;
	logic [7:0]  psize_q;

	phase_t      phase_n;
	logic [7:0]  bc_n;
	logic [7:0]  slen_n;
	logic [63:0] asm_n;
	logic [63:0] held_n;
	logic [31:0] total_n;
	logic [31:0] done_n;
	logic        big_n;
	logic        cpx_n;
	logic        flt_n;
	logic [7:0]  psize_n;

	logic enable;

	assign enable = step.valid && advance;

	always_comb begin
		phase_t      ph;
		logic [7:0]  bc;
		logic [7:0]  slen;
		logic [63:0] asm_v;
		logic [63:0] held;
		logic [31:0] total;
		logic [31:0] done;
		logic        big;
		logic        cpx;
		logic        flt;
		logic [7:0]  b;
		logic [7:0]  bc_inc;
		logic [63:0] asm_le;
		logic [63:0] asm_cmp;
		logic [63:0] comp;
		logic [7:0]  hdr_len;
		logic [31:0] done_inc;
		logic        size_ok;
		logic        none;
		logic        fin;

		b = step.word.data_byte;

		// A start flag drops any frame in progress and restarts at the skip phase with cleared state.
		if (step.word.frame_start) begin
			ph    = PH_SKIP;
			bc    = '0;
			slen  = '0;
			asm_v = '0;
			held  = '0;
			total = '0;
			done  = '0;
			big   = 1'b0;
			cpx   = 1'b0;
			flt   = 1'b0;
		end else begin
			ph    = phase_q;
			bc    = bc_q;
			slen  = slen_q;
			asm_v = asm_q;
			held  = held_q;
			total = total_q;
			done  = done_q;
			big   = big_q;
			cpx   = cpx_q;
			flt   = flt_q;
		end

		phase_n = ph;
		bc_n    = bc;
		slen_n  = slen;
		asm_n   = asm_v;
		held_n  = held;
		total_n = total;
		done_n  = done;
		big_n   = big;
		cpx_n   = cpx;
		flt_n   = flt;
		psize_n = step.word.frame_start ? 8'd0 : psize_q;

		result       = '0;
		result.valid = 1'b0;

		bc_inc   = bc + 8'd1;
		asm_le   = asm_v | (64'(b) << {bc[2:0], 3'b000});
		asm_cmp  = big ? {asm_v[55:0], b} : asm_le;
		done_inc = done + 32'd1;
		fin      = bc_inc >= psize_q;
		size_ok  = 1'b0;
		none     = 1'b0;
		comp     = asm_cmp;
		if (psize_q == 8'd1 && !flt && asm_cmp[7]) begin
			comp[63:8] = '1;
		end

		case (ph)
			PH_FNUM:  hdr_len = 8'(FRAME_NUMBER_BYTES);
			PH_TIME:  hdr_len = 8'(TIME_BYTES);
			default:  hdr_len = 8'(HEADER_WORD_BYTES);
		endcase

		case (ph)
			PH_SKIP: begin
				bc_n = bc_inc;
				if (bc_inc >= 8'(SKIP_BYTES)) begin
					bc_n    = '0;
					phase_n = PH_FNUM;
				end
			end
			PH_FNUM, PH_XDIV, PH_YDIV, PH_COUNT, PH_XOFF, PH_TIME: begin
				bc_n  = bc_inc;
				asm_n = asm_le;
				if (bc_inc >= hdr_len) begin
					bc_n                  = '0;
					asm_n                 = '0;
					result.valid          = 1'b1;
					result.word.value     = asm_le;
					case (ph)
						PH_FNUM: begin
							result.word.kind = KIND_FNUM;
							phase_n          = PH_TYPE;
						end
						PH_XDIV: begin
							result.word.kind = KIND_XDIV;
							phase_n          = PH_YDIV;
						end
						PH_YDIV: begin
							result.word.kind = KIND_YDIV;
							phase_n          = PH_COUNT;
						end
						PH_COUNT: begin
							result.word.kind = KIND_COUNT;
							total_n          = asm_le[31:0];
							phase_n          = PH_XOFF;
						end
						PH_XOFF: begin
							result.word.kind = KIND_XOFF;
							phase_n          = PH_TIME;
						end
						default: begin
							result.word.kind = KIND_TIME;
							phase_n          = PH_FEND;
						end
					endcase
				end
			end
			PH_TYPE: begin
				if (b != TYPE_ACCEPTED) begin
					phase_n           = PH_IDLE;
					result.valid      = 1'b1;
					result.word.kind  = KIND_REJECT;
					result.word.value = 64'(b);
					result.word.last  = 1'b1;
				end else begin
					phase_n = PH_SLEN0;
				end
			end
			PH_SLEN0, PH_SLEN1, PH_SLEN2: begin
				// Round the length up so that length byte plus text fill 4-byte words.
				slen_n = b + {6'b0, ~b[1:0]};
				bc_n   = '0;
				case (ph)
					PH_SLEN0: phase_n = PH_SSKIP0;
					PH_SLEN1: phase_n = PH_SSKIP1;
					default:  phase_n = PH_SSKIP2;
				endcase
			end
			PH_SSKIP0, PH_SSKIP1, PH_SSKIP2: begin
				bc_n = bc_inc;
				if (bc_inc >= slen) begin
					bc_n = '0;
					case (ph)
						PH_SSKIP0: phase_n = PH_SLEN1;
						PH_SSKIP1: phase_n = PH_SLEN2;
						default:   phase_n = PH_XDIV;
					endcase
				end
			end
			PH_FEND: begin
				big_n   = big || (b != 8'd0);
				phase_n = PH_FCPX;
			end
			PH_FCPX: begin
				cpx_n   = cpx || (b != 8'd0);
				phase_n = PH_FFLT;
			end
			PH_FFLT: begin
				flt_n   = flt || (b != 8'd0);
				phase_n = PH_FSIZE;
			end
			PH_FSIZE: begin
				psize_n = b;
				if (flt) begin
					size_ok = b inside {8'd4, 8'd8};
				end else begin
					size_ok = b inside {8'd1, 8'd2, 8'd4, 8'd8};
				end
				none                   = !size_ok || (total == 32'd0);
				phase_n                = none ? PH_IDLE : PH_REAL;
				bc_n                   = '0;
				asm_n                  = '0;
				result.valid           = 1'b1;
				result.word.kind       = KIND_FORMAT;
				result.word.value      = 64'(big);
				result.word.is_complex = cpx;
				result.word.is_float   = flt;
				result.word.point_size = b;
				result.word.last       = none;
			end
			PH_REAL, PH_IMAG: begin
				bc_n  = bc_inc;
				asm_n = asm_cmp;
				if (fin) begin
					bc_n  = '0;
					asm_n = '0;
					if (cpx && ph == PH_REAL) begin
						held_n  = comp;
						phase_n = PH_IMAG;
					end else begin
						done_n                   = done_inc;
						phase_n                  = (done_inc == total) ? PH_IDLE : PH_REAL;
						result.valid             = 1'b1;
						result.word.kind         = KIND_SAMPLE;
						result.word.value        = (ph == PH_IMAG) ? held : comp;
						result.word.imag_value   = (ph == PH_IMAG) ? comp : 64'd0;
						result.word.sample_index = done;
						result.word.is_complex   = cpx;
						result.word.is_float     = flt;
						result.word.point_size   = psize_q;
						result.word.last         = done_inc == total;
					end
				end
			end
			default: begin
			end
		endcase

		result.valid = result.valid && step.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bc_q    <= '0;
			slen_q  <= '0;
			asm_q   <= '0;
			held_q  <= '0;
			total_q <= '0;
			done_q  <= '0;
			big_q   <= 1'b0;
			cpx_q   <= 1'b0;
			flt_q   <= 1'b0;
			psize_q <= '0;
		end else if (enable) begin
			phase_q <= phase_n;
			bc_q    <= bc_n;
			slen_q  <= slen_n;
			asm_q   <= asm_n;
			held_q  <= held_n;
			total_q <= total_n;
			done_q  <= done_n;
			big_q   <= big_n;
			cpx_q   <= cpx_n;
			flt_q   <= flt_n;
			psize_q <= psize_n;
		end
	end

endmodule

/* rtl/core/sfp_out_stage.sv */
// Result register of the scope frame parser and the stage advance signal.
// Depends on sfp_pkg for the result types.
module sfp_out_stage
	import sfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  result_t   result,
	output logic      advance,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	logic      res_valid_q;
	res_word_t res_word_q;

	// Advance whenever the result register is empty or being drained.
	assign advance = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			res_word_q <= result.word;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

/* rtl/core/scope_frame_parser.sv */
// Top level of the scope frame parser: input register, parser, result register.
// Depends on sfp_pkg, sfp_in_stage, sfp_parser and sfp_out_stage.
//
// Usage:
//   frame_* carries one stream byte per word with a start flag on the first
//   byte of a frame. res_* carries at most one result word per byte: the
//   header values, the format word, each sample, or a reject word. The final
//   result of a frame has last set.
// Throughput: one byte per cycle while res_stall holds no result, with no gaps between frames.
// Pipeline: a byte in the input register is parsed combinationally, and its
//   result (if any) is loaded into the result register when the stage advances;
//   these registers are the only stages, all parsing happens between them.
// Stall: when res_stall holds a pending result, the result register and the
//   input register hold, and frame_stall rises only if the input register is
//   also occupied; bytes that produce no result still need the stage to move.
// Reset: arst_n clears both valid bits and returns the parser to idle; bytes
//   arriving while idle are dropped until a word with frame_start set.
// A start flag in mid-frame drops the frame in progress with no result.
module scope_frame_parser
	import sfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frame_valid,
	output logic      frame_stall,
	input  in_word_t  frame_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	step_t   step;
	result_t result;
	logic    advance;

	// Capture the incoming byte; hold it while the result side is blocked.
	sfp_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_word  (frame_word),
		.advance     (advance),
		.step        (step)
	);

	// Advance the frame state by one byte and form its result.
	sfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.advance (advance),
		.result  (result)
	);

	// Hold the result until the receiver takes it.
	sfp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.advance   (advance),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

/* rtl/core/sfp_checker.sv */
// Port-level checks of the scope frame parser, bound to its top level.
// Depends on sfp_pkg and scope_frame_parser_defines.svh.
`include "scope_frame_parser_defines.svh"

module sfp_checker
	import sfp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      frame_valid,
	input logic      frame_stall,
	input in_word_t  frame_word,
	input logic      res_valid,
	input logic      res_stall,
	input res_word_t res_word
);

	// A stalled input word stays put.
	`SFP_ASSERT(a_in_hold, frame_valid && frame_stall |=> frame_valid && $stable(frame_word), "input changed while stalled")

	// A stalled result stays put.
	`SFP_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_word), "result changed while stalled")

	// Input backpressure only comes from a blocked result.
	`SFP_ASSERT_IMPL(a_stall_cause, frame_stall, res_valid && res_stall, "input stalled without result stall")

	// Only samples carry an imaginary part or an index.
	`SFP_ASSERT_IMPL(a_nonsample_zero, res_valid && res_word.kind != KIND_SAMPLE, res_word.imag_value == 64'd0 && res_word.sample_index == 32'd0, "non-sample result with sample fields")

	// A reject ends the frame and carries no format.
	`SFP_ASSERT_IMPL(a_reject_last, res_valid && res_word.kind == KIND_REJECT, res_word.last && res_word.point_size == 8'd0 && res_word.value[63:8] == 56'd0, "reject result malformed")

endmodule

bind scope_frame_parser sfp_checker u_sfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame_valid),
	.frame_stall (frame_stall),
	.frame_word  (frame_word),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.res_word    (res_word)
);

/* bench/tb_scope_frame_parser.sv */
// Self-checking bench for scope_frame_parser: feeds framed byte streams, predicts
// every result word in step with the accepted bytes and compares field by field.
// Depends on sfp_pkg and the scope_frame_parser RTL only.
`timescale 1ns / 1ps

module tb_scope_frame_parser;
	import sfp_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_BYTES    = 80;
	localparam int DRAIN_CYCLES   = 20000;
	localparam int TAIL_CYCLES    = 8;
	localparam longint TIMEOUT_CYCLES = 400000;

	// Bit positions inside the latched format flags.
	localparam int FMT_BIG_ENDIAN = 0;
	localparam int FMT_COMPLEX    = 1;
	localparam int FMT_FLOAT      = 2;

	// Sample layouts the frame builder knows how to produce.
	typedef enum int {
		SH_INT1,
		SH_INT2,
		SH_INT4,
		SH_INT8,
		SH_FLT4,
		SH_FLT8,
		SH_CPX_INT1,
		SH_CPX_FLT8,
		SH_CPX_INT2,
		SH_BAD_SIZE,
		SH_NO_SAMPLES,
		SH_COUNT
	} frame_shape_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      frame_valid = 1'b0;
	logic      frame_stall;
	in_word_t  frame_word = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_word_t res_word;

	scope_frame_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_word (frame_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stimulus bytes waiting for the driver, and result words owed by the parser.
	in_word_t  byte_stream[$];
	res_word_t expected_results[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int bytes_accepted = 0;
	int bytes_queued = 0;
	int results_checked = 0;
	int frames_built = 0;
	int frames_rejected = 0;
	int input_stall_cycles = 0;

	logic long_hold_req = 1'b0;
	logic long_hold = 1'b0;
	int   hold_count = 0;

	// Parser shadow state, advanced once per accepted byte.
	phase_t      ph_now = PH_IDLE;
	logic [7:0]  byte_idx = '0;
	logic [7:0]  str_skip = '0;
	logic [63:0] gather = '0;
	logic [63:0] held_re = '0;
	logic [31:0] sample_cnt = '0;
	logic [31:0] sample_seen = '0;
	logic [10:0] fmt_bits = '0;

	function automatic void clear_parse_state();
		ph_now = PH_IDLE;
		byte_idx = '0;
		str_skip = '0;
		gather = '0;
		held_re = '0;
		sample_cnt = '0;
		sample_seen = '0;
		fmt_bits = '0;
	endfunction

	// Little-endian header gathering; true once n bytes are in.
	function automatic bit gather_le(input logic [7:0] b, input int unsigned n);
		gather |= 64'(b) << (8 * byte_idx[2:0]);
		byte_idx++;
		if (byte_idx >= n) begin
			byte_idx = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the shadow parser by one byte; true when it yields a result word.
	function automatic bit parse_byte(input in_word_t w, output res_word_t r);
		logic [7:0]  b;
		logic [7:0]  sz;
		logic [63:0] v;
		bit          got;
		bit          none;
		bit          size_ok;
		b = w.data_byte;
		r = '0;
		got = 1'b0;
		// A start flag anywhere drops the frame in progress and restarts here.
		if (w.frame_start) begin
			clear_parse_state();
			ph_now = PH_SKIP;
		end
		sz = fmt_bits[10:3];
		case (ph_now)
			PH_SKIP: begin
				byte_idx++;
				if (byte_idx >= SKIP_BYTES) begin
					byte_idx = '0;
					ph_now = PH_FNUM;
				end
			end
			PH_FNUM: begin
				if (gather_le(b, FRAME_NUMBER_BYTES)) begin
					r.kind = KIND_FNUM;
					r.value = gather;
					gather = '0;
					ph_now = PH_TYPE;
					got = 1'b1;
				end
			end
			PH_TYPE: begin
				if (b != TYPE_ACCEPTED) begin
					r.kind = KIND_REJECT;
					r.value = 64'(b);
					r.last = 1'b1;
					ph_now = PH_IDLE;
					got = 1'b1;
				end else begin
					ph_now = PH_SLEN0;
				end
			end
			PH_SLEN0, PH_SLEN1, PH_SLEN2: begin
				// Length plus padding always lands on 3 mod 4.
				str_skip = b + ((8'd3 - b) & 8'd3);
				byte_idx = '0;
				ph_now = phase_t'(ph_now + 1);
			end
			PH_SSKIP0, PH_SSKIP1, PH_SSKIP2: begin
				byte_idx++;
				if (byte_idx >= str_skip) begin
					byte_idx = '0;
					ph_now = phase_t'(ph_now + 1);
				end
			end
			PH_XDIV, PH_YDIV, PH_COUNT, PH_XOFF, PH_TIME: begin
				if (gather_le(b, ph_now == PH_TIME ? TIME_BYTES : HEADER_WORD_BYTES)) begin
					case (ph_now)
						PH_XDIV:  r.kind = KIND_XDIV;
						PH_YDIV:  r.kind = KIND_YDIV;
						PH_COUNT: begin
							r.kind = KIND_COUNT;
							sample_cnt = gather[31:0];
						end
						PH_XOFF:  r.kind = KIND_XOFF;
						default:  r.kind = KIND_TIME;
					endcase
					r.value = gather;
					gather = '0;
					ph_now = phase_t'(ph_now + 1);
					got = 1'b1;
				end
			end
			PH_FEND: begin
				if (b != 0) fmt_bits[FMT_BIG_ENDIAN] = 1'b1;
				ph_now = PH_FCPX;
			end
			PH_FCPX: begin
				if (b != 0) fmt_bits[FMT_COMPLEX] = 1'b1;
				ph_now = PH_FFLT;
			end
			PH_FFLT: begin
				if (b != 0) fmt_bits[FMT_FLOAT] = 1'b1;
				ph_now = PH_FSIZE;
			end
			PH_FSIZE: begin
				fmt_bits[10:3] = b;
				if (fmt_bits[FMT_FLOAT])
					size_ok = (b == 4) || (b == 8);
				else
					size_ok = (b == 1) || (b == 2) || (b == 4) || (b == 8);
				none = !size_ok || (sample_cnt == 0);
				ph_now = none ? PH_IDLE : PH_REAL;
				byte_idx = '0;
				gather = '0;
				r.kind = KIND_FORMAT;
				r.value = 64'(fmt_bits[FMT_BIG_ENDIAN]);
				r.is_complex = fmt_bits[FMT_COMPLEX];
				r.is_float = fmt_bits[FMT_FLOAT];
				r.point_size = fmt_bits[10:3];
				r.last = none;
				got = 1'b1;
			end
			PH_REAL, PH_IMAG: begin
				if (fmt_bits[FMT_BIG_ENDIAN])
					gather = {gather[55:0], b};
				else
					gather |= 64'(b) << (8 * byte_idx[2:0]);
				byte_idx++;
				if (byte_idx >= sz) begin
					byte_idx = '0;
					v = gather;
					gather = '0;
					// Only one-byte integers get sign extension.
					if (sz == 1 && !fmt_bits[FMT_FLOAT] && v[7]) v[63:8] = '1;
					if (fmt_bits[FMT_COMPLEX] && ph_now == PH_REAL) begin
						held_re = v;
						ph_now = PH_IMAG;
					end else begin
						r.kind = KIND_SAMPLE;
						if (ph_now == PH_IMAG) begin
							r.value = held_re;
							r.imag_value = v;
						end else begin
							r.value = v;
						end
						r.sample_index = sample_seen;
						sample_seen++;
						r.last = (sample_seen == sample_cnt);
						ph_now = r.last ? PH_IDLE : PH_REAL;
						r.is_complex = fmt_bits[FMT_COMPLEX];
						r.is_float = fmt_bits[FMT_FLOAT];
						r.point_size = fmt_bits[10:3];
						got = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return got;
	endfunction

	// Driver: hold a stalled word, otherwise offer the next queued byte or go idle.
	always @(posedge clk) begin : drive_proc
		res_word_t pred;
		bit        advance;
		if (arst_n) begin
			if (frame_valid && frame_stall) input_stall_cycles++;
			advance = !frame_valid || !frame_stall;
			if (frame_valid && !frame_stall) begin
				bytes_accepted++;
				if (parse_byte(frame_word, pred))
					expected_results.insert(expected_results.size(), pred);
			end
			if (advance) begin
				if (byte_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					frame_word <= byte_stream.pop_front();
					frame_valid <= 1'b1;
				end else begin
					frame_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
		end
	endtask

	// Monitor: compare every accepted word with the oldest prediction, then pick
	// the stall for the next cycle.
	always @(posedge clk) begin : watch_proc
		res_word_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$error("unexpected result word, kind %0d value %0h",
						res_word.kind, res_word.value);
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 64'(want.kind), 64'(res_word.kind));
					check_field("value", want.value, res_word.value);
					check_field("imag_value", want.imag_value, res_word.imag_value);
					check_field("sample_index", 64'(want.sample_index),
						64'(res_word.sample_index));
					check_field("is_complex", 64'(want.is_complex), 64'(res_word.is_complex));
					check_field("is_float", 64'(want.is_float), 64'(res_word.is_float));
					check_field("point_size", 64'(want.point_size), 64'(res_word.point_size));
					check_field("last", 64'(want.last), 64'(res_word.last));
					results_checked++;
				end
			end
			res_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Long hold-off of the result side, counted here so the sender keeps pushing
	// until the parser backs up into frame_stall.
	always @(posedge clk) begin
		if (long_hold) begin
			if (hold_count == HOLD_CYCLES) long_hold <= 1'b0;
			hold_count <= hold_count + 1;
		end else if (long_hold_req) begin
			long_hold <= 1'b1;
			hold_count <= 0;
		end
	end

	task automatic push_byte(input logic [7:0] b, input bit start);
		in_word_t w;
		w.data_byte = b;
		w.frame_start = start;
		byte_stream.insert(byte_stream.size(), w);
		bytes_queued++;
	endtask

	task automatic push_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) push_byte(v[8 * i +: 8], 1'b0);
	endtask

	// Flag bytes: any nonzero value counts as set, so use random nonzero values.
	task automatic push_flag(input bit on);
		push_byte(on ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0);
	endtask

	// Build one frame with random content. Faults (rejected type, huge sample
	// count cut short by the next start, truncation) only when allowed.
	task automatic build_frame(input frame_shape_t shape, input bit allow_faults);
		int unsigned base;
		int unsigned comps;
		int unsigned cut;
		logic [31:0] total;
		logic [7:0]  size_b;
		logic [7:0]  len_b;
		logic [7:0]  span;
		logic [7:0]  type_b;
		bit          cpx;
		bit          flt;
		bit          big;
		bit          huge;
		bit          bad;
		in_word_t    noise;
		base = byte_stream.size();
		cpx = 1'b0;
		flt = 1'b0;
		size_b = 8'd1;
		case (shape)
			SH_INT1:     size_b = 8'd1;
			SH_INT2:     size_b = 8'd2;
			SH_INT4:     size_b = 8'd4;
			SH_INT8:     size_b = 8'd8;
			SH_FLT4:     begin flt = 1'b1; size_b = 8'd4; end
			SH_FLT8:     begin flt = 1'b1; size_b = 8'd8; end
			SH_CPX_INT1: begin cpx = 1'b1; size_b = 8'd1; end
			SH_CPX_FLT8: begin cpx = 1'b1; flt = 1'b1; size_b = 8'd8; end
			SH_CPX_INT2: begin cpx = 1'b1; size_b = 8'd2; end
			SH_BAD_SIZE: begin
				flt = 1'($urandom_range(0, 1));
				cpx = 1'($urandom_range(0, 1));
				do begin
					size_b = 8'($urandom_range(0, 255));
					if (flt)
						bad = !(size_b == 4 || size_b == 8);
					else
						bad = !(size_b == 1 || size_b == 2 || size_b == 4 || size_b == 8);
				end while (!bad);
			end
			default: begin
				flt = 1'($urandom_range(0, 1));
				cpx = 1'($urandom_range(0, 1));
				size_b = flt ? ($urandom_range(0, 1) ? 8'd4 : 8'd8)
					: 8'd1 << $urandom_range(0, 3);
			end
		endcase
		huge = allow_faults && ($urandom_range(0, 7) == 0);
		if (shape == SH_NO_SAMPLES)
			total = '0;
		else if (huge || shape == SH_BAD_SIZE)
			total = $urandom | 32'h0000_0100;
		else
			total = $urandom_range(1, size_b == 1 ? 12 : 4);
		big = 1'($urandom_range(0, 1));

		push_byte(8'($urandom), 1'b1);
		for (int i = 1; i < SKIP_BYTES; i++) push_byte(8'($urandom), 1'b0);
		push_le({$urandom, $urandom}, FRAME_NUMBER_BYTES);
		if (allow_faults && $urandom_range(0, 11) == 0) begin
			do type_b = 8'($urandom); while (type_b == TYPE_ACCEPTED);
			push_byte(type_b, 1'b0);
			frames_rejected++;
		end else begin
			push_byte(TYPE_ACCEPTED, 1'b0);
			// Mostly short strings; now and then one of any length up to 255.
			for (int s = 0; s < 3; s++) begin
				len_b = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 6));
				push_byte(len_b, 1'b0);
				span = len_b + ((8'd3 - len_b) & 8'd3);
				for (int i = 0; i < span; i++) push_byte(8'($urandom), 1'b0);
			end
			push_le(64'($urandom), HEADER_WORD_BYTES);
			push_le(64'($urandom), HEADER_WORD_BYTES);
			push_le(64'(total), HEADER_WORD_BYTES);
			push_le(64'($urandom), HEADER_WORD_BYTES);
			push_le({$urandom, $urandom}, TIME_BYTES);
			push_flag(big);
			push_flag(cpx);
			push_flag(flt);
			push_byte(size_b, 1'b0);
			if (shape != SH_BAD_SIZE && total != 0) begin
				comps = huge ? $urandom_range(0, 6) : total * (cpx ? 2 : 1);
				for (int i = 0; i < comps * size_b; i++) push_byte(8'($urandom), 1'b0);
			end
		end
		if (allow_faults && $urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, 60);
			while (byte_stream.size() > base + cut) begin
				void'(byte_stream.pop_back());
				bytes_queued--;
			end
		end
		frames_built++;
		// Stray bytes between frames: ignored while idle, payload if mid-frame.
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				noise.data_byte = 8'($urandom);
				noise.frame_start = 1'b0;
				byte_stream.insert(byte_stream.size(), noise);
			end
		end
	endtask

	// Set the idling mix, queue about budget bytes of frames, wait for them to go.
	task automatic run_phase(input int idle_pct, input int hold_pct, input int budget);
		int start;
		@(negedge clk);
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		start = bytes_queued;
		// The first frames walk every sample layout once, without faults.
		while (bytes_queued - start < budget) begin
			if (frames_built < SH_COUNT)
				build_frame(frame_shape_t'(frames_built), 1'b0);
			else
				build_frame(frame_shape_t'($urandom_range(0, SH_COUNT - 1)), 1'b1);
		end
		while (byte_stream.size() != 0) @(negedge clk);
	endtask

	initial begin : stim_proc
		int guard;
		clear_parse_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: bytes while idle, rejects with type 0 and 255 at the extreme
		// frame numbers, and a frame dropped by a start in mid-header.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hA5, 1'b1);
		repeat (SKIP_BYTES - 1) push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		repeat (SKIP_BYTES - 1) push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		while (byte_stream.size() != 0) @(negedge clk);

		run_phase(0, 0, PHASE_BYTES);
		run_phase(46, 0, PHASE_BYTES);
		run_phase(0, 46, PHASE_BYTES);
		run_phase(24, 24, PHASE_BYTES);

		// Back-pressure: hold off the result side while the sender keeps going.
		long_hold_req = 1'b1;
		while (!long_hold) @(negedge clk);
		long_hold_req = 1'b0;
		run_phase(0, 0, PHASE_BYTES);
		while (long_hold) @(negedge clk);

		// Drain, then give the two-stage pipe a few more cycles for strays.
		guard = 0;
		while ((byte_stream.size() != 0 || frame_valid || expected_results.size() != 0)
				&& guard < DRAIN_CYCLES) begin
			@(negedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_results.size() != 0 || byte_stream.size() != 0) begin
			errors++;
			$error("%0d result words never arrived, %0d bytes never sent",
				expected_results.size(), byte_stream.size());
		end

		$display("Run covered %0d frames (%0d rejected) in %0d bytes, %0d result words checked.",
			frames_built, frames_rejected, bytes_accepted, results_checked);
		$display("Input side stalled for %0d cycles across five idling mixes.",
			input_stall_cycles);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog_proc
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL");
		$finish;
	end

endmodule
